/* rtl/core/blpg_pkg.sv */
// Shared types and constants for the Bresenham line pixel generator.
package blpg_pkg;

    localparam int CFG_W       = 11;
    localparam int COORD_IN_W  = 16;
    localparam int COLOR_W     = 32;
    localparam int ADDR_W      = 20;
    localparam int PIX_W       = 10;
    localparam int STATUS_W    = 2;
    localparam int REG_IDX_W   = 1;
    localparam int MAX_DIM_DEF = 1024;

    localparam logic [CFG_W-1:0] SURF_WIDTH_RESET  = CFG_W'(320);
    localparam logic [CFG_W-1:0] SURF_HEIGHT_RESET = CFG_W'(200);

    typedef enum logic
    {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_PIXEL  = 2'd0,
        ST_REJECT = 2'd1,
        ST_IDLE   = 2'd2
    } status_t;

    typedef enum logic [REG_IDX_W-1:0]
    {
        REG_SURFACE_WIDTH  = 1'b0,
        REG_SURFACE_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic                  operation;
        logic [COORD_IN_W-1:0] x_start;
        logic [COORD_IN_W-1:0] y_start;
        logic [COORD_IN_W-1:0] x_end;
        logic [COORD_IN_W-1:0] y_end;
        logic [COLOR_W-1:0]    line_color;
    } cmd_beat_t;

    typedef struct packed
    {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   pixel_address;
        logic [PIX_W-1:0]    pixel_x;
        logic [PIX_W-1:0]    pixel_y;
        logic [COLOR_W-1:0]  pixel_color;
        logic                last;
    } pix_beat_t;

    // Per-pixel side information between the stepper and the address stage.
    typedef struct packed
    {
        logic [STATUS_W-1:0] status;
        logic                last;
    } pix_ctrl_t;

endpackage

/* rtl/core/blpg_stepper.sv */
// Line setup and per-pixel Bresenham step, with the pixel stage register.
module blpg_stepper
    import blpg_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    localparam int CW     = $clog2(MAX_DIM),
    localparam int DW     = $clog2(MAX_DIM + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    input  cmd_beat_t     item,
    input  logic [DW-1:0] width_eff,
    input  logic [DW-1:0] height_eff,
    input  logic          pix_free,
    output logic          take,
    output logic          pix_valid,
    output logic [CW-1:0] pix_x,
    output logic [CW-1:0] pix_y,
    output logic [COLOR_W-1:0] pix_color,
    output pix_ctrl_t     pix_ctrl
);

    localparam int ERR_W = CW + 2;
    localparam int CMP_W = (DW > COORD_IN_W) ? DW : COORD_IN_W;

    // line state
    logic                    line_active_reg, line_active_next;
    logic                    steep_reg;
    logic [CW-1:0]           major_pos_reg, major_end_reg, minor_pos_reg;
    logic                    step_down_reg;
    logic [CW-1:0]           major_delta_reg, minor_delta_reg;
    logic signed [ERR_W-1:0] error_reg;
    logic [COLOR_W-1:0]      color_reg;

    // pixel stage
    logic                    valid_reg;
    logic [CW-1:0]           px_reg, py_reg;
    logic [COLOR_W-1:0]      pcolor_reg;
    pix_ctrl_t               ctrl_reg;

    logic                    en;
    logic                    is_start, in_bounds, emit, fin;
    logic [CW-1:0]           x0, y0, x1, y1, adx, ady;
    logic                    steep;
    logic [CW-1:0]           a0r, b0r, a1r, b1r, a0, b0, a1, b1;
    logic [CW-1:0]           mdel, ndel;
    logic                    down;
    logic                    cur_steep, cur_down;
    logic [CW-1:0]           cur_major, cur_end, cur_minor, cur_mdel, cur_ndel;
    logic signed [ERR_W-1:0] cur_err, err_sub, err_next;
    logic [COLOR_W-1:0]      cur_color;
    logic [CW-1:0]           minor_next, major_next, px, py;
    status_t                 status;

    assign en   = !valid_reg || pix_free;
    assign take = item_valid && en;

    always_comb
    begin
        is_start = (op_t'(item.operation) == OP_START);
        in_bounds = (CMP_W'(item.x_start) < CMP_W'(width_eff))
                 && (CMP_W'(item.x_end)   < CMP_W'(width_eff))
                 && (CMP_W'(item.y_start) < CMP_W'(height_eff))
                 && (CMP_W'(item.y_end)   < CMP_W'(height_eff));

        x0 = item.x_start[CW-1:0];
        y0 = item.y_start[CW-1:0];
        x1 = item.x_end[CW-1:0];
        y1 = item.y_end[CW-1:0];
        adx = (x1 > x0) ? x1 - x0 : x0 - x1;
        ady = (y1 > y0) ? y1 - y0 : y0 - y1;
        steep = (ady > adx);

        a0r = steep ? y0 : x0;
        b0r = steep ? x0 : y0;
        a1r = steep ? y1 : x1;
        b1r = steep ? x1 : y1;
        // order so the major coordinate increases
        if (a0r > a1r)
        begin
            a0 = a1r; b0 = b1r; a1 = a0r; b1 = b0r;
        end
        else
        begin
            a0 = a0r; b0 = b0r; a1 = a1r; b1 = b1r;
        end
        mdel = a1 - a0;
        ndel = (b1 > b0) ? b1 - b0 : b0 - b1;
        down = !(b0 < b1);

        if (is_start)
        begin
            cur_steep = steep;
            cur_major = a0;
            cur_end   = a1;
            cur_minor = b0;
            cur_down  = down;
            cur_mdel  = mdel;
            cur_ndel  = ndel;
            cur_err   = ERR_W'(mdel >> 1);
            cur_color = item.line_color;
            emit      = in_bounds;
            status    = in_bounds ? ST_PIXEL : ST_REJECT;
        end
        else
        begin
            cur_steep = steep_reg;
            cur_major = major_pos_reg;
            cur_end   = major_end_reg;
            cur_minor = minor_pos_reg;
            cur_down  = step_down_reg;
            cur_mdel  = major_delta_reg;
            cur_ndel  = minor_delta_reg;
            cur_err   = error_reg;
            cur_color = color_reg;
            emit      = line_active_reg;
            status    = line_active_reg ? ST_PIXEL : ST_IDLE;
        end

        px  = cur_steep ? cur_minor : cur_major;
        py  = cur_steep ? cur_major : cur_minor;
        fin = (cur_major >= cur_end);

        err_sub = cur_err - $signed({2'b00, cur_ndel});
        if (err_sub < 0)
        begin
            minor_next = cur_down ? cur_minor - 1'b1 : cur_minor + 1'b1;
            err_next   = err_sub + $signed({2'b00, cur_mdel});
        end
        else
        begin
            minor_next = cur_minor;
            err_next   = err_sub;
        end
        major_next = fin ? cur_major : cur_major + 1'b1;
        line_active_next = emit && !fin;
    end

    // hold line state; advance on every taken beat that draws
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
        end
        else if (take)
        begin
            line_active_reg <= line_active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            steep_reg       <= cur_steep;
            major_pos_reg   <= major_next;
            major_end_reg   <= cur_end;
            minor_pos_reg   <= minor_next;
            step_down_reg   <= cur_down;
            major_delta_reg <= cur_mdel;
            minor_delta_reg <= cur_ndel;
            error_reg       <= err_next;
            color_reg       <= cur_color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            px_reg          <= emit ? px : '0;
            py_reg          <= emit ? py : '0;
            pcolor_reg      <= emit ? cur_color : '0;
            ctrl_reg.status <= status;
            ctrl_reg.last   <= emit && fin;
        end
    end

    assign pix_valid = valid_reg;
    assign pix_x     = px_reg;
    assign pix_y     = py_reg;
    assign pix_color = pcolor_reg;
    assign pix_ctrl  = ctrl_reg;

endmodule

/* rtl/core/blpg_addr.sv */
// Framebuffer address stage and output register.
module blpg_addr
    import blpg_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    localparam int CW     = $clog2(MAX_DIM),
    localparam int DW     = $clog2(MAX_DIM + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pix_valid,
    input  logic [CW-1:0]      pix_x,
    input  logic [CW-1:0]      pix_y,
    input  logic [COLOR_W-1:0] pix_color,
    input  pix_ctrl_t          pix_ctrl,
    input  logic [DW-1:0]      stride,
    input  logic               out_stall,
    output logic               pix_free,
    output logic               out_valid,
    output pix_beat_t          out_beat
);

    localparam int PW = CW + DW + 1;

    logic      valid_reg;
    pix_beat_t beat_reg, beat_next;
    logic [PW-1:0] addr_sum;

    assign pix_free = !valid_reg || !out_stall;

    always_comb
    begin
        addr_sum = PW'(pix_y) * PW'(stride) + PW'(pix_x);
        beat_next.status        = pix_ctrl.status;
        beat_next.pixel_address = ADDR_W'(addr_sum);
        beat_next.pixel_x       = PIX_W'(pix_x);
        beat_next.pixel_y       = PIX_W'(pix_y);
        beat_next.pixel_color   = pix_color;
        beat_next.last          = pix_ctrl.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pix_free)
        begin
            valid_reg <= pix_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_free && pix_valid)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

/* rtl/core/bresenham_line_pixel_generator_core.sv */
// Top level of the Bresenham line pixel generator.
//
// Command channel (cmd_valid / cmd_stall / cmd_beat): an operation of start
// carries two endpoints and a color; an operation of advance asks for the
// next pixel of the current line. Every command beat yields exactly one
// pixel beat on pix_valid / pix_stall / pix_beat: a pixel with its linear
// address y * width + x and a last flag, a rejection when an endpoint lies
// outside the surface, or an idle status when no line is in progress.
// Configuration writes (cfg_write, cfg_index, cfg_data) set the surface
// width and height; write them only while no command is in flight.
// Between an accepted command and its pixel beat lie the command register,
// the stepper register and the address register.
// Throughput: one command per cycle unless pix_stall holds; the line state
// loops in the stepper, so back-to-back advances draw one pixel a clock.
// Reset clears all pipeline valids and drops any line in progress; the
// surface registers return to 320 by 200. When the receiver stalls, hold
// the pixel beat; the stages behind it still fill, and cmd_stall rises only
// once every stage holds a beat.
module bresenham_line_pixel_generator_core
    import blpg_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  cmd_beat_t            cmd_beat,
    output logic                 pix_valid,
    input  logic                 pix_stall,
    output pix_beat_t            pix_beat,
    input  logic                 cfg_write,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int CW    = $clog2(MAX_DIM);
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int CMP_W = (DW > CFG_W) ? DW : CFG_W;

    logic [CFG_W-1:0] surf_width_reg, surf_height_reg;
    logic [DW-1:0]    width_eff, height_eff;

    logic       cmd_valid_reg;
    cmd_beat_t  cmd_reg;
    logic       take;

    logic               step_valid;
    logic [CW-1:0]      step_x, step_y;
    logic [COLOR_W-1:0] step_color;
    pix_ctrl_t          step_ctrl;
    logic               pix_free;

    // Surface size registers; sizes beyond MAX_DIM saturate.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            surf_width_reg  <= SURF_WIDTH_RESET;
            surf_height_reg <= SURF_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_SURFACE_WIDTH:  surf_width_reg  <= cfg_data;
                REG_SURFACE_HEIGHT: surf_height_reg <= cfg_data;
            endcase
        end
    end

    assign width_eff  = (CMP_W'(surf_width_reg) > CMP_W'(MAX_DIM))
                      ? DW'(MAX_DIM) : DW'(surf_width_reg);
    assign height_eff = (CMP_W'(surf_height_reg) > CMP_W'(MAX_DIM))
                      ? DW'(MAX_DIM) : DW'(surf_height_reg);

    // Command register: accept whenever empty or draining into the stepper.
    assign cmd_stall = cmd_valid_reg && !take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            cmd_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            cmd_reg <= cmd_beat;
        end
    end

    blpg_stepper #(
        .MAX_DIM (MAX_DIM)
    ) u_stepper (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (cmd_valid_reg),
        .item       (cmd_reg),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .pix_free   (pix_free),
        .take       (take),
        .pix_valid  (step_valid),
        .pix_x      (step_x),
        .pix_y      (step_y),
        .pix_color  (step_color),
        .pix_ctrl   (step_ctrl)
    );

    blpg_addr #(
        .MAX_DIM (MAX_DIM)
    ) u_addr (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (step_valid),
        .pix_x     (step_x),
        .pix_y     (step_y),
        .pix_color (step_color),
        .pix_ctrl  (step_ctrl),
        .stride    (width_eff),
        .out_stall (pix_stall),
        .pix_free  (pix_free),
        .out_valid (pix_valid),
        .out_beat  (pix_beat)
    );

endmodule

/* rtl/core/blpg_checker.sv */
// Port-level checks for the line pixel generator, bound to the top level.
module blpg_checker
    import blpg_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cmd_valid,
    input logic                 cmd_stall,
    input cmd_beat_t            cmd_beat,
    input logic                 pix_valid,
    input logic                 pix_stall,
    input pix_beat_t            pix_beat,
    input logic                 cfg_write,
    input logic [REG_IDX_W-1:0] cfg_index,
    input logic [CFG_W-1:0]     cfg_data
);

    logic [2:0] outstanding_reg;
    logic       cmd_take, pix_take;

    assign cmd_take = cmd_valid && !cmd_stall;
    assign pix_take = pix_valid && !pix_stall;

    // count commands whose pixel beat is not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_reg + 3'(cmd_take) - 3'(pix_take);
        end
    end

    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_stall |=> pix_valid && $stable(pix_beat))
        else $error("pixel beat changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid |-> outstanding_reg != 3'd0)
        else $error("pixel beat without a pending command");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= 3'd3)
        else $error("more commands in flight than pipeline stages");

    a_no_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_beat.status != ST_PIXEL |->
            pix_beat.pixel_address == '0 && pix_beat.pixel_x == '0
            && pix_beat.pixel_y == '0 && pix_beat.pixel_color == '0
            && !pix_beat.last)
        else $error("reject or idle beat carries pixel data");

    // configuration is checked elsewhere; keep the port list complete
    logic unused_cfg;
    assign unused_cfg = cfg_write ^ (^cfg_index) ^ (^cfg_data) ^ (^cmd_beat);

endmodule

bind bresenham_line_pixel_generator_core blpg_checker u_checker (.*);

/* dv/testbench.sv */
// Self-checking testbench for the Bresenham line pixel generator core.
`timescale 1ns / 100ps

module testbench;
    import blpg_pkg::*;

    // Watchdog: cycles without any accepted beat or register write.
    localparam int QUIET_LIMIT    = 2000;
    // Length of the long output hold-off that backs up the pipeline.
    localparam int RX_HOLD_CYCLES = 120;
    // Random command beats per surface setting.
    localparam int PHASE_ITEMS    = 170;
    // Surface settings after the reset-default one.
    localparam int NUM_PHASES     = 9;
    // Settle time after the last pixel beat (three register stages deep).
    localparam int DRAIN_CYCLES   = 8;

    localparam cmd_beat_t ADVANCE_BEAT =
        cmd_beat_t'{OP_ADVANCE, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0};
    localparam pix_beat_t REJECT_BEAT =
        pix_beat_t'{ST_REJECT, 20'd0, 10'd0, 10'd0, 32'd0, 1'b0};
    localparam pix_beat_t IDLE_BEAT =
        pix_beat_t'{ST_IDLE, 20'd0, 10'd0, 10'd0, 32'd0, 1'b0};

    // One row of the directed table: the beat to send and, where it can be
    // read off directly, the pixel beat it must produce.
    typedef struct
    {
        cmd_beat_t beat;
        bit        typed;
        pix_beat_t want;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cmd_valid;
    logic                 cmd_stall;
    cmd_beat_t            cmd_beat;
    logic                 pix_valid;
    logic                 pix_stall;
    pix_beat_t            pix_beat;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // Travels with each command beat: use cmd_want instead of the predictor.
    logic                 cmd_typed;
    pix_beat_t            cmd_want;

    // Predictor copy of the surface registers and the line walker.
    logic [CFG_W-1:0]     surf_w;
    logic [CFG_W-1:0]     surf_h;
    logic                 line_on;
    logic                 line_steep;
    logic                 minor_down;
    logic [PIX_W-1:0]     major_at;
    logic [PIX_W-1:0]     major_stop;
    logic [PIX_W-1:0]     minor_at;
    logic [PIX_W-1:0]     major_span;
    logic [PIX_W-1:0]     minor_span;
    logic signed [11:0]   slope_err;
    logic [COLOR_W-1:0]   line_color_q;

    pix_beat_t            pending_pixels[$];
    dir_row_t             dir_rows[$];

    bit                   hold_req = 1'b0;
    bit                   no_gaps  = 1'b0;
    int unsigned          quiet_cycles    = 0;
    int unsigned          fail_count      = 0;
    int unsigned          beats_sent      = 0;
    int unsigned          pixels_seen     = 0;
    int unsigned          rejects_seen    = 0;
    int unsigned          idles_seen      = 0;
    int unsigned          held_off_cycles = 0;

    bresenham_line_pixel_generator_core #(
        .MAX_DIM (MAX_DIM_DEF)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_beat  (cmd_beat),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_beat  (pix_beat),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Registers above the maximum surface size saturate, both as bound and
    // as row stride.
    function automatic logic [CFG_W-1:0] surface_limit(input logic [CFG_W-1:0] r);
        return (r > MAX_DIM_DEF) ? CFG_W'(MAX_DIM_DEF) : r;
    endfunction

    // Emit the pixel at the current position, then take one major step unless it is the last.
    function automatic pix_beat_t plot_step();
        pix_beat_t        res;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic             at_end;
        px = line_steep ? minor_at : major_at;
        py = line_steep ? major_at : minor_at;
        at_end = (major_at >= major_stop);
        res.status        = ST_PIXEL;
        res.pixel_address = ADDR_W'(int'(py) * int'(surface_limit(surf_w)) + int'(px));
        res.pixel_x       = px;
        res.pixel_y       = py;
        res.pixel_color   = line_color_q;
        res.last          = at_end;
        slope_err = slope_err - $signed({2'b00, minor_span});
        if (slope_err < 0)
        begin
            minor_at  = minor_down ? minor_at - 1'b1 : minor_at + 1'b1;
            slope_err = slope_err + $signed({2'b00, major_span});
        end
        if (at_end)
            line_on = 1'b0;
        else
            major_at = major_at + 1'b1;
        return res;
    endfunction

    // Work out the pixel beat that one command beat produces.
    function automatic pix_beat_t trace_pixel(input cmd_beat_t c);
        pix_beat_t             res;
        logic [CFG_W-1:0]      w;
        logic [CFG_W-1:0]      h;
        logic [COORD_IN_W-1:0] adx;
        logic [COORD_IN_W-1:0] ady;
        logic [COORD_IN_W-1:0] a0;
        logic [COORD_IN_W-1:0] b0;
        logic [COORD_IN_W-1:0] a1;
        logic [COORD_IN_W-1:0] b1;
        res = '0;
        w = surface_limit(surf_w);
        h = surface_limit(surf_h);
        if (c.operation == OP_START)
        begin
            // Any start drops the line in progress, even a rejected one.
            line_on = 1'b0;
            if (c.x_start >= w || c.x_end >= w || c.y_start >= h || c.y_end >= h)
            begin
                res.status = ST_REJECT;
            end
            else
            begin
                adx = (c.x_end > c.x_start) ? c.x_end - c.x_start : c.x_start - c.x_end;
                ady = (c.y_end > c.y_start) ? c.y_end - c.y_start : c.y_start - c.y_end;
                line_steep = (ady > adx);
                if (line_steep)
                begin
                    a0 = c.y_start; b0 = c.x_start; a1 = c.y_end; b1 = c.x_end;
                end
                else
                begin
                    a0 = c.x_start; b0 = c.y_start; a1 = c.x_end; b1 = c.y_end;
                end
                // Walk the major axis upward.
                if (a0 > a1)
                begin
                    {a0, a1} = {a1, a0};
                    {b0, b1} = {b1, b0};
                end
                major_at     = PIX_W'(a0);
                major_stop   = PIX_W'(a1);
                minor_at     = PIX_W'(b0);
                major_span   = PIX_W'(a1 - a0);
                minor_span   = PIX_W'((b1 > b0) ? b1 - b0 : b0 - b1);
                minor_down   = !(b0 < b1);
                slope_err    = $signed({3'b000, major_span[PIX_W-1:1]});
                line_color_q = c.line_color;
                line_on      = 1'b1;
                res = plot_step();
            end
        end
        else if (line_on)
        begin
            res = plot_step();
        end
        else
        begin
            res.status = ST_IDLE;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: predict on every accepted command beat, check every
    // accepted pixel beat against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        pix_beat_t predicted;
        pix_beat_t oldest;
        if (!rst_n)
        begin
            surf_w       = SURF_WIDTH_RESET;
            surf_h       = SURF_HEIGHT_RESET;
            line_on      = 1'b0;
            line_steep   = 1'b0;
            minor_down   = 1'b0;
            major_at     = '0;
            major_stop   = '0;
            minor_at     = '0;
            major_span   = '0;
            minor_span   = '0;
            slope_err    = '0;
            line_color_q = '0;
            quiet_cycles = 0;
            pending_pixels.delete();
        end
        else
        begin
            quiet_cycles++;
            if (cfg_write)
            begin
                quiet_cycles = 0;
                if (cfg_index == REG_SURFACE_WIDTH)
                    surf_w = cfg_data;
                else
                    surf_h = cfg_data;
            end
            if (cmd_valid && cmd_stall)
                held_off_cycles++;
            if (cmd_valid && !cmd_stall)
            begin
                quiet_cycles = 0;
                // Run the predictor even for typed rows so its line state
                // follows the block.
                predicted = trace_pixel(cmd_beat);
                pending_pixels.push_back(cmd_typed ? cmd_want : predicted);
            end
            if (pix_valid && !pix_stall)
            begin
                quiet_cycles = 0;
                case (pix_beat.status)
                    ST_PIXEL:  pixels_seen++;
                    ST_REJECT: rejects_seen++;
                    default:   idles_seen++;
                endcase
                if (pending_pixels.size() == 0)
                begin
                    $error("pixel beat with nothing expected: status %0d address %0d",
                           pix_beat.status, pix_beat.pixel_address);
                    fail_count++;
                end
                else
                begin
                    oldest = pending_pixels.pop_front();
                    if (pix_beat.status !== oldest.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               oldest.status, pix_beat.status);
                        fail_count++;
                    end
                    if (pix_beat.pixel_address !== oldest.pixel_address)
                    begin
                        $error("pixel_address: expected %0d, got %0d",
                               oldest.pixel_address, pix_beat.pixel_address);
                        fail_count++;
                    end
                    if (pix_beat.pixel_x !== oldest.pixel_x)
                    begin
                        $error("pixel_x: expected %0d, got %0d",
                               oldest.pixel_x, pix_beat.pixel_x);
                        fail_count++;
                    end
                    if (pix_beat.pixel_y !== oldest.pixel_y)
                    begin
                        $error("pixel_y: expected %0d, got %0d",
                               oldest.pixel_y, pix_beat.pixel_y);
                        fail_count++;
                    end
                    if (pix_beat.pixel_color !== oldest.pixel_color)
                    begin
                        $error("pixel_color: expected %h, got %h",
                               oldest.pixel_color, pix_beat.pixel_color);
                        fail_count++;
                    end
                    if (pix_beat.last !== oldest.last)
                    begin
                        $error("last: expected %0d, got %0d",
                               oldest.last, pix_beat.last);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic cmd_beat_t start_beat(input int x0, input int y0, input int x1,
                                             input int y1, input logic [31:0] color);
        return cmd_beat_t'{OP_START, COORD_IN_W'(x0), COORD_IN_W'(y0),
                           COORD_IN_W'(x1), COORD_IN_W'(y1), color};
    endfunction

    function automatic pix_beat_t lit_pixel(input int x, input int y, input int addr,
                                            input logic [31:0] color, input logic fin);
        return pix_beat_t'{ST_PIXEL, ADDR_W'(addr), PIX_W'(x), PIX_W'(y), color, fin};
    endfunction

    function automatic void add_row(input cmd_beat_t b, input bit typed,
                                    input pix_beat_t w);
        dir_row_t r;
        r.beat  = b;
        r.typed = typed;
        r.want  = w;
        dir_rows.push_back(r);
    endfunction

    // A coordinate close to base, clamped onto the surface.
    function automatic logic [COORD_IN_W-1:0] near_coord(input logic [COORD_IN_W-1:0] base,
                                                        input int unsigned dim);
        int v;
        v = int'(base) + int'($urandom_range(0, 24)) - 12;
        if (v < 0)
            v = 0;
        if (v >= int'(dim))
            v = int'(dim) - 1;
        return COORD_IN_W'(v);
    endfunction

    // A coordinate at or past the bound, up to the top of the field.
    function automatic logic [COORD_IN_W-1:0] far_coord(input int unsigned dim);
        if ($urandom_range(0, 3) == 0)
            return '1;
        return COORD_IN_W'($urandom_range(dim, 65535));
    endfunction

    // Offer one beat, hold it until taken. The previous beat's valid is
    // only lowered when a gap comes first.
    task automatic send_cmd(input cmd_beat_t c, input bit typed, input pix_beat_t want);
        int unsigned gap;
        gap = no_gaps ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_beat  <= c;
        cmd_typed <= typed;
        cmd_want  <= want;
        do
            @(posedge clk);
        while (cmd_stall);
        beats_sent++;
    endtask

    task automatic idle_cmd();
        @(negedge clk);
        cmd_valid <= 1'b0;
    endtask

    // Wait until every expected pixel beat is in, then let the pipe settle.
    task automatic wait_drained();
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // One start followed by the advances that walk its line: usually the
    // exact count, sometimes cut short (the next start abandons it) and
    // sometimes a few too many (idle beats). A tenth of the starts put one
    // endpoint off the surface. Stop the advances once the beat count
    // reaches cap, so long lines do not overshoot the phase budget.
    task automatic draw_random_line(input int unsigned w, input int unsigned h,
                                    input int unsigned cap);
        cmd_beat_t   c;
        int unsigned span;
        int unsigned steps;
        int unsigned roll;
        int          dx;
        int          dy;
        c = '0;
        c.operation  = OP_START;
        c.line_color = $urandom;
        c.x_start = (w != 0) ? COORD_IN_W'($urandom_range(0, w - 1)) : COORD_IN_W'($urandom);
        c.y_start = (h != 0) ? COORD_IN_W'($urandom_range(0, h - 1)) : COORD_IN_W'($urandom);
        if (w != 0 && h != 0 && $urandom_range(0, 9) != 0)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                c.x_end = near_coord(c.x_start, w);
                c.y_end = near_coord(c.y_start, h);
            end
            else
            begin
                c.x_end = COORD_IN_W'($urandom_range(0, w - 1));
                c.y_end = COORD_IN_W'($urandom_range(0, h - 1));
            end
            dx = int'(c.x_end) - int'(c.x_start);
            dy = int'(c.y_end) - int'(c.y_start);
            if (dx < 0)
                dx = -dx;
            if (dy < 0)
                dy = -dy;
            span = (dx > dy) ? dx : dy;
            roll = $urandom_range(0, 99);
            if (roll < 75)
                steps = span;
            else if (roll < 90)
                steps = $urandom_range(0, span);
            else
                steps = span + $urandom_range(1, 3);
        end
        else
        begin
            c.x_end = (w != 0) ? COORD_IN_W'($urandom_range(0, w - 1)) : COORD_IN_W'($urandom);
            c.y_end = (h != 0) ? COORD_IN_W'($urandom_range(0, h - 1)) : COORD_IN_W'($urandom);
            case ($urandom_range(0, 3))
                0:       c.x_start = far_coord(w);
                1:       c.y_start = far_coord(h);
                2:       c.x_end   = far_coord(w);
                default: c.y_end   = far_coord(h);
            endcase
            steps = $urandom_range(0, 3);
        end
        // Some lines go out back to back.
        no_gaps = hold_req || ($urandom_range(0, 4) == 0);
        send_cmd(c, 1'b0, '0);
        while (steps != 0 && beats_sent < cap)
        begin
            send_cmd(ADVANCE_BEAT, 1'b0, '0);
            steps--;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls with stretches of none, plus one long hold
    // on request that lets the whole pipe back up into cmd_stall.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int unsigned run_left;
        int unsigned stall_left;
        pix_stall  = 1'b0;
        run_left   = 0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                pix_stall <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                pix_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (run_left != 0)
            begin
                pix_stall <= 1'b0;
                run_left--;
            end
            else if (stall_left != 0)
            begin
                pix_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                pix_stall <= 1'b0;
                run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                          : $urandom_range(0, 6);
                stall_left = pick_gap();
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    initial
    begin : watchdog
        wait (rst_n === 1'b1);
        while (quiet_cycles < QUIET_LIMIT)
            @(negedge clk);
        $display("bresenham_line_pixel_generator_core test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned      target;
        logic [CFG_W-1:0] w_reg;
        logic [CFG_W-1:0] h_reg;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd_beat  = '0;
        cmd_typed = 1'b0;
        cmd_want  = '0;
        cfg_write = 1'b0;
        cfg_index = REG_SURFACE_WIDTH;
        cfg_data  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part on the reset surface of 320 by 200.
        add_row(ADVANCE_BEAT, 1'b1, IDLE_BEAT);                           // no line yet
        add_row(start_beat(5, 7, 5, 7, 32'hC0FFEE11), 1'b1,
                lit_pixel(5, 7, 2245, 32'hC0FFEE11, 1'b1));              // single point
        add_row(ADVANCE_BEAT, 1'b1, IDLE_BEAT);                           // line is done
        add_row(start_beat(0, 0, 319, 199, 32'hFFFFFFFF), 1'b1,
                lit_pixel(0, 0, 0, 32'hFFFFFFFF, 1'b0));                 // corner to corner
        add_row(ADVANCE_BEAT, 1'b0, '0);
        add_row(ADVANCE_BEAT, 1'b0, '0);
        add_row(start_beat(320, 0, 0, 0, 32'h1), 1'b1, REJECT_BEAT);      // x at the bound
        add_row(ADVANCE_BEAT, 1'b1, IDLE_BEAT);                           // reject dropped line
        add_row(start_beat(0, 0, 0, 200, 32'h2), 1'b1, REJECT_BEAT);      // y at the bound
        add_row(start_beat(65535, 65535, 65535, 65535, 32'hFFFFFFFF), 1'b1, REJECT_BEAT);
        add_row(start_beat(319, 199, 319, 199, 32'h0), 1'b1,
                lit_pixel(319, 199, 63999, 32'h0, 1'b1));                // far corner
        add_row(start_beat(10, 3, 7, 20, 32'hA5A5A5A5), 1'b0, '0);        // steep, x falls
        add_row(ADVANCE_BEAT, 1'b0, '0);
        add_row(ADVANCE_BEAT, 1'b0, '0);
        add_row(ADVANCE_BEAT, 1'b0, '0);
        add_row(start_beat(100, 150, 90, 140, 32'h5A5A5A5A), 1'b0, '0);   // restart, reversed
        add_row(ADVANCE_BEAT, 1'b0, '0);
        add_row(ADVANCE_BEAT, 1'b0, '0);
        add_row(start_beat(3, 0, 3, 4, 32'h12345678), 1'b0, '0);          // vertical
        add_row(ADVANCE_BEAT, 1'b0, '0);
        add_row(ADVANCE_BEAT, 1'b0, '0);
        add_row(ADVANCE_BEAT, 1'b0, '0);
        add_row(ADVANCE_BEAT, 1'b0, '0);
        add_row(ADVANCE_BEAT, 1'b1, IDLE_BEAT);                           // past the end
        add_row(start_beat(319, 10, 0, 12, 32'h0F0F0F0F), 1'b0, '0);      // long and shallow
        foreach (dir_rows[i])
            send_cmd(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

        // Back up the pipe: receiver holds off while lines keep coming.
        target = beats_sent + PHASE_ITEMS;
        hold_req = 1'b1;
        while (hold_req)
            draw_random_line(320, 200, target);
        no_gaps = 1'b0;

        while (beats_sent < target)
            draw_random_line(320, 200, target);
        idle_cmd();
        wait_drained();

        // Random part over further surface settings, extremes included:
        // one by one, saturating values, zero in either register.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       begin w_reg = 11'd64;   h_reg = 11'd48;   end
                1:       begin w_reg = 11'd1;    h_reg = 11'd1;    end
                2:       begin w_reg = 11'd1024; h_reg = 11'd1024; end
                3:       begin w_reg = 11'd2047; h_reg = 11'd1025; end
                4:       begin w_reg = 11'd0;    h_reg = 11'd37;   end
                5:       begin w_reg = 11'd45;   h_reg = 11'd0;    end
                6:       begin w_reg = 11'd7;    h_reg = 11'd90;   end
                7:       begin w_reg = 11'd300;  h_reg = 11'd17;   end
                default:
                begin
                    w_reg = CFG_W'($urandom_range(1, 2047));
                    h_reg = CFG_W'($urandom_range(1, 2047));
                end
            endcase
            write_reg(REG_SURFACE_WIDTH, w_reg);
            write_reg(REG_SURFACE_HEIGHT, h_reg);
            target = beats_sent + PHASE_ITEMS;
            while (beats_sent < target)
                draw_random_line(surface_limit(w_reg), surface_limit(h_reg), target);
            idle_cmd();
            wait_drained();
        end

        $display("Sent %0d command beats over %0d surface sizes, zero and oversize included.",
                 beats_sent, NUM_PHASES + 1);
        $display("Got %0d pixels, %0d rejects, %0d idle beats; input held off %0d cycles.",
                 pixels_seen, rejects_seen, idles_seen, held_off_cycles);
        if (fail_count == 0 && pending_pixels.size() == 0)
            $display("bresenham_line_pixel_generator_core test passed");
        else
            $display("bresenham_line_pixel_generator_core test failed");
        $finish;
    end

endmodule
